// ----- src/bdq_pkg.sv -----
// Shared constants, operation and status codes, and the result type of the deque block.
package bdq_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int M_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_INSERT_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
    } bdq_res_t;

endpackage

// ----- src/bdq_mem.sv -----
// Entry store: single-port-write, single-port-read synchronous memory with registered read data.
module bdq_mem
    import bdq_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEFAULT,
    parameter int ADDR_W = $clog2(CAPACITY_DEFAULT)
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bdq_ctrl.sv -----
// Deque controller: ring pointers, entry count, and the sequential search scan over the store.
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int PTR_W    = $clog2(CAPACITY_DEFAULT),
    parameter int CNT_W    = $clog2(CAPACITY_DEFAULT + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    in_op,
    input  logic [VALUE_W-1:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output bdq_res_t           res,
    output logic               mem_we,
    output logic [PTR_W-1:0]   mem_waddr,
    output logic [VALUE_W-1:0] mem_wdata,
    output logic               mem_re,
    output logic [PTR_W-1:0]   mem_raddr,
    input  logic [VALUE_W-1:0] mem_rdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    bdq_res_t           res_reg, res_next;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic [PTR_W-1:0]   front_dec;
    logic [PTR_W:0]     back_sum;
    logic [PTR_W-1:0]   back_addr;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - PTR_W'(1);

    // The count is below capacity whenever the back address is used, so its low bits suffice.
    assign back_sum  = {1'b0, front_reg} + {1'b0, count_reg[PTR_W-1:0]};
    assign back_addr = (back_sum >= (PTR_W + 1)'(CAPACITY))
                     ? PTR_W'(back_sum - (PTR_W + 1)'(CAPACITY))
                     : back_sum[PTR_W-1:0];

    always_comb begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        value_next = value_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = back_addr;
        mem_wdata  = in_value;
        mem_re     = 1'b0;
        mem_raddr  = front_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next   = '{found: 1'b0, status: STATUS_OK};
                    value_next = in_value;
                    state_next = ST_DONE;
                    case (in_op)
                        OP_INSERT_FRONT: begin
                            if (is_full) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT_BACK: begin
                            if (is_full) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE_FRONT: begin
                            if (is_empty) begin
                                res_next.status = STATUS_EMPTY;
                            end else begin
                                front_next = ring_inc(front_reg);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_REMOVE_BACK: begin
                            if (is_empty) begin
                                res_next.status = STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (!is_empty) begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                pos_next   = ring_inc(front_reg);
                                left_next  = count_reg;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Read data belongs to the read issued last cycle; the next read overlaps the compare.
                if (mem_rdata == value_reg) begin
                    res_next.found = 1'b1;
                    state_next     = ST_DONE;
                end else if (left_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = pos_reg;
                    pos_next  = ring_inc(pos_reg);
                    left_next = left_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// ----- src/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search: controller, entry store and output register.
//
// A bounded double-ended queue of up to CAPACITY signed 32-bit values held in one synchronous
// memory used as a ring. Each input item carries an operation in s_tuser (insert front, insert
// back, remove front, remove back, search) and a value in s_tdata, and yields exactly one result
// item with a found flag and a status (ok, removal from empty, insert refused because full).
// One item is worked on at a time. Inserts, removals, unused operation codes and a search of an
// empty sequence write their result to the controller's result register and from there to the
// output register, and the next item can be accepted once the controller has handed the result
// over. A search reads the store one entry per cycle through its single read port, starting at
// the front; it stops at the first entry that matches the value, or after all n entries when
// there is no match, and its result then takes the same path to the output register. When the
// output register still holds an unaccepted result, the finished item waits in the controller
// until m_tready frees the register. A new item is accepted while the previous result waits in
// the output register. There is no clearing pass after reset: only written entries are ever
// read.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]     s_tuser,   // [2:0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] found, [2:1] status, [7:3] zero
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               res_valid;
    logic               res_ready;
    bdq_res_t           res;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               m_valid_reg, m_valid_next;
    bdq_res_t           m_res_reg, m_res_next;

    bdq_ctrl #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdq_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (PTR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a new result when empty or when its item leaves this cycle.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - STATUS_W - 1)'(0), m_res_reg.status, m_res_reg.found};

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while an item was still being worked on.");

    a_found_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == STATUS_OK)
        else $error("A found result carries a status other than ok.");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_tvalid)
        else $error("A handed-over result did not reach the output register.");

    a_no_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("Controller offers a result while ready for a new item.");
`endif

endmodule
